[rtl/ms_pkg.sv]
// Package for the merge sorter: shared types and constants.
// No dependencies; compiled first.
`default_nettype none
package ms_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS,
    ST_READ,
    ST_MERGE,
    ST_FETCH,
    ST_EMIT
  } ms_state_t;

endpackage
`default_nettype wire

[rtl/ms_in_if.sv]
// Input request channel of the merge sorter: valid/ready plus one element.
// Depends on ms_pkg.
`default_nettype none
interface ms_in_if;
  logic          valid;
  logic          ready;
  ms_pkg::data_t value;
  logic          last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface
`default_nettype wire

[rtl/ms_out_if.sv]
// Result request channel of the merge sorter: valid/ready plus one element.
// Depends on ms_pkg.
`default_nettype none
interface ms_out_if;
  logic          valid;
  logic          ready;
  ms_pkg::data_t sorted_value;
  logic          last_result;

  modport source (output valid, output sorted_value, output last_result, input ready);
  modport sink   (input valid, input sorted_value, input last_result, output ready);
endinterface
`default_nettype wire

[rtl/ms_mem.sv]
// Ping-pong element memory: two banks, one write port, two registered read ports.
// Depends on ms_pkg.
`default_nettype none
module ms_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic          wr_bank,
  input  wire logic [AW-1:0] wr_addr,
  input  wire ms_pkg::data_t wr_data,
  input  wire logic          rd_bank,
  input  wire logic [AW-1:0] rd_addr_a,
  input  wire logic [AW-1:0] rd_addr_b,
  output ms_pkg::data_t      rd_data_a,
  output ms_pkg::data_t      rd_data_b
);

  ms_pkg::data_t bank0 [DEPTH];
  ms_pkg::data_t bank1 [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en && !wr_bank) begin
      bank0[wr_addr] <= wr_data;
    end
    if (wr_en && wr_bank) begin
      bank1[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_bank) begin
      rd_data_a <= bank1[rd_addr_a];
      rd_data_b <= bank1[rd_addr_b];
    end else begin
      rd_data_a <= bank0[rd_addr_a];
      rd_data_b <= bank0[rd_addr_b];
    end
  end

endmodule
`default_nettype wire

[rtl/ms_ctrl.sv]
// Sequencer of the merge sorter: load, bottom-up merge passes, emit.
// Depends on ms_pkg, ms_in_if, ms_out_if; drives the ports of ms_mem.
`default_nettype none
module ms_ctrl #(
  parameter int MAX_ELEMENTS = 8,
  parameter int AW           = 3
) (
  input  wire logic          clk,
  input  wire logic          rst,
  ms_in_if.sink              items,
  ms_out_if.source           results,
  output logic               wr_en,
  output logic               wr_bank,
  output logic [AW-1:0]      wr_addr,
  output ms_pkg::data_t      wr_data,
  output logic               rd_bank,
  output logic [AW-1:0]      rd_addr_a,
  output logic [AW-1:0]      rd_addr_b,
  input  wire ms_pkg::data_t rd_data_a,
  input  wire ms_pkg::data_t rd_data_b
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int PW = AW + 3;

  ms_pkg::ms_state_t state, state_next;

  logic [CW-1:0] cnt, cnt_next;
  logic          src, src_next;
  logic [PW-1:0] width, width_next;
  logic [PW-1:0] lo, lo_next;
  logic [PW-1:0] a, a_next;
  logic [PW-1:0] b, b_next;
  logic [PW-1:0] k, k_next;
  logic [PW-1:0] a_end, a_end_next;
  logic [PW-1:0] b_end, b_end_next;

  logic          out_valid, out_valid_next;
  ms_pkg::data_t out_value, out_value_next;
  logic          out_last, out_last_next;

  logic          accept;
  logic          set_done;
  logic [PW-1:0] n_ext;
  logic [PW-1:0] mid_raw, hi_raw, mid_sat, hi_sat;
  logic          a_ok, b_ok, take_a;
  logic          slot_free;
  logic          emit_last;
  logic          merge_done;

  assign accept     = items.valid && items.ready;
  assign set_done   = items.last_item || (cnt == CW'(MAX_ELEMENTS - 1));
  assign n_ext      = PW'(cnt);
  assign mid_raw    = lo + width;
  assign hi_raw     = lo + (width << 1);
  assign mid_sat    = (mid_raw > n_ext) ? n_ext : mid_raw;
  assign hi_sat     = (hi_raw > n_ext) ? n_ext : hi_raw;
  assign a_ok       = a < a_end;
  assign b_ok       = b < b_end;
  assign take_a     = a_ok && (!b_ok || (rd_data_a <= rd_data_b));
  assign merge_done = (k + PW'(1)) == b_end;
  assign slot_free  = !out_valid || results.ready;
  assign emit_last  = (k + PW'(1)) == n_ext;

  always_comb begin
    state_next = state;
    unique case (state)
      ms_pkg::ST_LOAD: begin
        if (accept && set_done) begin
          state_next = ms_pkg::ST_PASS;
        end
      end
      ms_pkg::ST_PASS: begin
        if (width >= n_ext) begin
          state_next = ms_pkg::ST_FETCH;
        end else if (lo < n_ext) begin
          state_next = ms_pkg::ST_READ;
        end
      end
      ms_pkg::ST_READ:  state_next = ms_pkg::ST_MERGE;
      ms_pkg::ST_MERGE: state_next = merge_done ? ms_pkg::ST_PASS : ms_pkg::ST_READ;
      ms_pkg::ST_FETCH: state_next = ms_pkg::ST_EMIT;
      ms_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_next = emit_last ? ms_pkg::ST_LOAD : ms_pkg::ST_FETCH;
        end
      end
      default: state_next = ms_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cnt_next       = cnt;
    src_next       = src;
    width_next     = width;
    lo_next        = lo;
    a_next         = a;
    b_next         = b;
    k_next         = k;
    a_end_next     = a_end;
    b_end_next     = b_end;
    out_value_next = out_value;
    out_last_next  = out_last;
    out_valid_next = out_valid && !results.ready;
    items.ready    = 1'b0;
    wr_en          = 1'b0;
    wr_bank        = 1'b0;
    wr_addr        = cnt[AW-1:0];
    wr_data        = items.value;
    rd_bank        = src;
    rd_addr_a      = a[AW-1:0];
    rd_addr_b      = b[AW-1:0];
    unique case (state)
      ms_pkg::ST_LOAD: begin
        items.ready = 1'b1;
        wr_en       = accept;
        if (accept) begin
          cnt_next = cnt + CW'(1);
          if (set_done) begin
            width_next = PW'(1);
            lo_next    = '0;
            src_next   = 1'b0;
          end
        end
      end
      ms_pkg::ST_PASS: begin
        if (width >= n_ext) begin
          k_next = '0;
        end else if (lo < n_ext) begin
          a_next     = lo;
          a_end_next = mid_sat;
          b_next     = mid_sat;
          b_end_next = hi_sat;
          k_next     = lo;
        end else begin
          width_next = width << 1;
          lo_next    = '0;
          src_next   = !src;
        end
      end
      ms_pkg::ST_READ: begin
      end
      ms_pkg::ST_MERGE: begin
        wr_en   = 1'b1;
        wr_bank = !src;
        wr_addr = k[AW-1:0];
        wr_data = take_a ? rd_data_a : rd_data_b;
        k_next  = k + PW'(1);
        if (take_a) begin
          a_next = a + PW'(1);
        end else begin
          b_next = b + PW'(1);
        end
        if (merge_done) begin
          lo_next = b_end;
        end
      end
      ms_pkg::ST_FETCH: begin
        rd_addr_a = k[AW-1:0];
      end
      ms_pkg::ST_EMIT: begin
        rd_addr_a = k[AW-1:0];
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_value_next = rd_data_a;
          out_last_next  = emit_last;
          k_next         = k + PW'(1);
          if (emit_last) begin
            cnt_next = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ms_pkg::ST_LOAD;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
    src       <= src_next;
    width     <= width_next;
    lo        <= lo_next;
    a         <= a_next;
    b         <= b_next;
    k         <= k_next;
    a_end     <= a_end_next;
    b_end     <= b_end_next;
    out_value <= out_value_next;
    out_last  <= out_last_next;
  end

  assign results.valid        = out_valid;
  assign results.sorted_value = out_value;
  assign results.last_result  = out_last;

endmodule
`default_nettype wire

[rtl/merge_sorter.sv]
// Merge sorter top level: ping-pong element memory plus merge sequencer.
// Depends on ms_pkg, ms_in_if, ms_out_if, ms_mem, ms_ctrl.
//
// Usage:
//   items   : request channel, one signed 32-bit element per request. The
//             request with last_item set, or the MAX_ELEMENTS-th request,
//             closes the set.
//   results : request channel, the set in ascending signed order; the final
//             request carries last_result.
// Sequence for a set of n elements:
//   load    : one element per cycle while items is valid.
//   sort    : ceil(log2 n) bottom-up merge passes; in each pass every element
//             goes through a memory read, then compare and write back, and
//             each run pair and each pass take a setup step.
//   emit    : per result a memory read, then the output register.
//   items is not ready during sort and emit; the next set loads once the
//   final result sits in the output register.
// Reset (rst, synchronous) empties the set and drops any pending result;
// memory contents are left as they are. A stalled results channel holds the
// output register and pauses the emit sequence.
`default_nettype none
module merge_sorter #(
  parameter int MAX_ELEMENTS = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  ms_in_if.sink     items,
  ms_out_if.source  results
);

  localparam int AW = $clog2(MAX_ELEMENTS);

  logic          wr_en;
  logic          wr_bank;
  logic [AW-1:0] wr_addr;
  ms_pkg::data_t wr_data;
  logic          rd_bank;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  ms_pkg::data_t rd_data_a;
  ms_pkg::data_t rd_data_b;

  ms_mem #(
    .DEPTH (MAX_ELEMENTS),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_bank   (wr_bank),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_bank   (rd_bank),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  ms_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .AW           (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .results   (results),
    .wr_en     (wr_en),
    .wr_bank   (wr_bank),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_bank   (rd_bank),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

endmodule
`default_nettype wire
